// File: hdl/lgs_pkg.sv
// Shared constants and types for the life generation step block.
// No dependencies; every other file but lgs_ram uses this package.
package lgs_pkg;

  localparam int unsigned MAX_COLS_DEF = 1024;
  localparam int unsigned MAX_ROWS_DEF = 1024;
  localparam int unsigned MIN_DIM      = 5;
  localparam int unsigned DIM_RESET    = 64;
  localparam int unsigned CFG_DATA_W   = 11;
  localparam int unsigned OUT_POS_W    = 10;
  // line store word: [1] row above, [0] row two above
  localparam int unsigned LINE_W       = 2;

  typedef enum logic [0:0] {
    CFG_ROW_COUNT = 1'b0,
    CFG_COL_COUNT = 1'b1
  } cfg_reg_e;

  // one scanned cell, handed from the scan stage to the window stage
  typedef struct packed {
    logic                 alive;
    logic                 emit;
    logic                 last;
    logic [OUT_POS_W-1:0] out_row;
    logic [OUT_POS_W-1:0] out_col;
  } item_t;

endpackage

// File: hdl/lgs_if.sv
// Handshake channels of the life generation step block: cell stream,
// result stream and configuration writes. Depends on lgs_pkg.
interface lgs_cell_if;
  logic valid;
  logic ready;
  logic cell_alive;
  logic frame_start;

  modport source (output valid, output cell_alive, output frame_start, input ready);
  modport sink   (input valid, input cell_alive, input frame_start, output ready);
endinterface

interface lgs_result_if;
  logic                           valid;
  logic                           ready;
  logic                           next_alive;
  logic [lgs_pkg::OUT_POS_W-1:0]  out_row;
  logic [lgs_pkg::OUT_POS_W-1:0]  out_col;
  logic                           last_cell;

  modport source (output valid, output next_alive, output out_row, output out_col,
                  output last_cell, input ready);
  modport sink   (input valid, input next_alive, input out_row, input out_col,
                  input last_cell, output ready);
endinterface

interface lgs_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [0:0]                     index;
  logic [lgs_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/lgs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lgs_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/lgs_scan.sv
// Scan stage: grid size registers, raster position tracking, border masking
// and per-cell control decode. Depends on lgs_pkg.
module lgs_scan #(
  parameter int unsigned MAX_COLS = lgs_pkg::MAX_COLS_DEF,
  parameter int unsigned MAX_ROWS = lgs_pkg::MAX_ROWS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [0:0]                        cfg_index_i,
  input  logic [lgs_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              accept_i,
  input  logic                              cell_alive_i,
  input  logic                              frame_start_i,
  output lgs_pkg::item_t                    item_o,
  output logic [$clog2(MAX_COLS)-1:0]       col_o
);
  import lgs_pkg::*;

  localparam int unsigned CAW  = $clog2(MAX_COLS);
  localparam int unsigned RAW  = $clog2(MAX_ROWS);
  localparam int unsigned CCW  = CAW + 1;
  localparam int unsigned RCW  = RAW + 1;
  localparam int unsigned CCMP = (CCW > CFG_DATA_W) ? CCW : CFG_DATA_W;
  localparam int unsigned RCMP = (RCW > CFG_DATA_W) ? RCW : CFG_DATA_W;
  localparam int unsigned COLS_RST = (DIM_RESET > MAX_COLS) ? MAX_COLS : DIM_RESET;
  localparam int unsigned ROWS_RST = (DIM_RESET > MAX_ROWS) ? MAX_ROWS : DIM_RESET;

  logic [RCW-1:0] rows_q, rows_d;
  logic [CCW-1:0] cols_q, cols_d;
  logic [RAW-1:0] row_q, row_d;
  logic [CAW-1:0] col_q, col_d;
  logic [RCMP-1:0] row_cfg;
  logic [CCMP-1:0] col_cfg;
  logic [RAW-1:0] r;
  logic [CAW-1:0] c;
  logic           restart;
  logic           row_end;
  logic           col_end;

  // clamp incoming counts to [MIN_DIM, MAX]
  always_comb begin
    rows_d  = rows_q;
    cols_d  = cols_q;
    row_cfg = RCMP'(cfg_data_i);
    col_cfg = CCMP'(cfg_data_i);
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_ROW_COUNT: begin
          if (row_cfg < RCMP'(MIN_DIM))       rows_d = RCW'(MIN_DIM);
          else if (row_cfg > RCMP'(MAX_ROWS)) rows_d = RCW'(MAX_ROWS);
          else                                rows_d = RCW'(row_cfg);
        end
        CFG_COL_COUNT: begin
          if (col_cfg < CCMP'(MIN_DIM))       cols_d = CCW'(MIN_DIM);
          else if (col_cfg > CCMP'(MAX_COLS)) cols_d = CCW'(MAX_COLS);
          else                                cols_d = CCW'(col_cfg);
        end
        default: begin
          rows_d = rows_q;
        end
      endcase
    end
  end

  always_comb begin
    restart = frame_start_i || ({1'b0, row_q} >= rows_q) || ({1'b0, col_q} >= cols_q);
    r = restart ? '0 : row_q;
    c = restart ? '0 : col_q;
    row_end = ({1'b0, r} == rows_q - RCW'(1));
    col_end = ({1'b0, c} == cols_q - CCW'(1));

    item_o.alive   = cell_alive_i && (r != '0) && (c != '0) && !row_end && !col_end;
    item_o.emit    = (r >= RAW'(2)) && (c >= CAW'(2));
    item_o.last    = row_end && col_end;
    item_o.out_row = OUT_POS_W'(r - RAW'(1));
    item_o.out_col = OUT_POS_W'(c - CAW'(1));
    col_o          = c;

    row_d = row_q;
    col_d = col_q;
    if (accept_i) begin
      if (col_end) begin
        col_d = '0;
        row_d = row_end ? '0 : r + RAW'(1);
      end else begin
        col_d = c + CAW'(1);
        row_d = r;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= RCW'(ROWS_RST);
      cols_q <= CCW'(COLS_RST);
      row_q  <= '0;
      col_q  <= '0;
    end else begin
      rows_q <= rows_d;
      cols_q <= cols_d;
      row_q  <= row_d;
      col_q  <= col_d;
    end
  end

`ifndef SYNTHESIS
  a_frame_start_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && frame_start_i |=> row_q == '0 && col_q == CAW'(1))
    else $error("frame start did not restart the raster position");
  a_pos_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept_i |=> $stable(row_q) && $stable(col_q))
    else $error("raster position moved without a transaction");
`endif

endmodule

// File: hdl/lgs_window.sv
// Window stage: line store bypass, 3x3 window shift, B3/S23 rule and the
// result register. Depends on lgs_pkg.
module lgs_window #(
  parameter int unsigned MAX_COLS = lgs_pkg::MAX_COLS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              accept_i,
  input  lgs_pkg::item_t                    item_i,
  input  logic [$clog2(MAX_COLS)-1:0]       col_i,
  output logic                              ready_o,
  input  logic [lgs_pkg::LINE_W-1:0]        line_rdata_i,
  output logic                              line_we_o,
  output logic [$clog2(MAX_COLS)-1:0]       line_waddr_o,
  output logic [lgs_pkg::LINE_W-1:0]        line_wdata_o,
  output logic                              res_valid_o,
  input  logic                              res_ready_i,
  output logic                              next_alive_o,
  output logic [lgs_pkg::OUT_POS_W-1:0]     out_row_o,
  output logic [lgs_pkg::OUT_POS_W-1:0]     out_col_o,
  output logic                              last_cell_o
);
  import lgs_pkg::*;

  localparam int unsigned CAW = $clog2(MAX_COLS);

  logic                  s1_valid_q, s1_valid_d;
  item_t                 item_q;
  logic [CAW-1:0]        col_q;
  logic                  fwd_q;
  logic [LINE_W-1:0]     fwd_data_q;
  logic [8:0]            win_q, win_d;
  logic                  advance;
  logic [LINE_W-1:0]     line_rd;
  logic [3:0]            count;
  logic                  alive;
  logic                  out_valid_q, out_valid_d;
  logic                  out_alive_q;
  logic [OUT_POS_W-1:0]  out_row_q, out_col_q;
  logic                  out_last_q;
  logic                  load;

  assign advance = s1_valid_q && (!item_q.emit || !out_valid_q || res_ready_i);
  assign ready_o = !s1_valid_q || advance;
  assign load    = advance && item_q.emit;

  // same-column write in the accept cycle is not yet visible in the RAM read
  assign line_rd = fwd_q ? fwd_data_q : line_rdata_i;

  assign line_we_o    = advance;
  assign line_waddr_o = col_q;
  assign line_wdata_o = {item_q.alive, line_rd[1]};

  // column bits: [0] two above, [1] above, [2] current
  always_comb begin
    win_d = {item_q.alive, line_rd[1], line_rd[0], win_q[8:3]};
    count = '0;
    for (int i = 0; i < 9; i++) begin
      if (i != 4) begin
        count = count + 4'(win_d[i]);
      end
    end
    alive = (count == 4'd3) || (win_d[4] && count == 4'd2);
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept_i)     s1_valid_d = 1'b1;
    else if (advance) s1_valid_d = 1'b0;

    out_valid_d = out_valid_q;
    if (load)             out_valid_d = 1'b1;
    else if (res_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      win_q       <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        win_q <= win_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      item_q     <= item_i;
      col_q      <= col_i;
      fwd_q      <= advance && (col_q == col_i);
      fwd_data_q <= line_wdata_o;
    end
    if (load) begin
      out_alive_q <= alive;
      out_row_q   <= item_q.out_row;
      out_col_q   <= item_q.out_col;
      out_last_q  <= item_q.last;
    end
  end

  assign res_valid_o  = out_valid_q;
  assign next_alive_o = out_alive_q;
  assign out_row_o    = out_row_q;
  assign out_col_o    = out_col_q;
  assign last_cell_o  = out_last_q;

`ifndef SYNTHESIS
  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_valid_q)
    else $error("emitting cell did not reach the result register");
  a_interior_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_row_q != '0 && out_col_q != '0)
    else $error("border cell presented as a result");
`endif

endmodule

// File: hdl/life_generation_step.sv
// Streaming Game of Life (B3/S23) generation step over a raster cell stream.
// Throughput: one cell per cycle unless result backpressure stalls the window stage,
// which drains into the result register. A cell that completes an interior neighborhood
// has its line store read at its transaction, then passes window, rule and result register.
// Reset: asynchronous, active low; grid size returns to 64x64, position and window clear.
// The line store is not cleared; entries are valid once the frame's rows have streamed.
module life_generation_step #(
  parameter int unsigned MAX_COLS = lgs_pkg::MAX_COLS_DEF,
  parameter int unsigned MAX_ROWS = lgs_pkg::MAX_ROWS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  lgs_cell_if.sink     cell_i,
  lgs_result_if.source result_o,
  lgs_cfg_if.sink      cfg_i
);
  import lgs_pkg::*;

  localparam int unsigned CAW = $clog2(MAX_COLS);

  logic              accept;
  logic              s1_ready;
  item_t             item;
  logic [CAW-1:0]    col;
  logic              line_we;
  logic [CAW-1:0]    line_waddr;
  logic [LINE_W-1:0] line_wdata;
  logic [LINE_W-1:0] line_rdata;

  // configuration is taken at any time; the user must write it only while idle, the block does not enforce this
  assign cfg_i.ready  = 1'b1;
  assign cell_i.ready = s1_ready;
  assign accept       = cell_i.valid && s1_ready;

  // scan stage: position, border mask, emit/last decode
  lgs_scan #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_i.valid),
    .cfg_index_i   (cfg_i.index),
    .cfg_data_i    (cfg_i.data),
    .accept_i      (accept),
    .cell_alive_i  (cell_i.cell_alive),
    .frame_start_i (cell_i.frame_start),
    .item_o        (item),
    .col_o         (col)
  );

  // both line buffers share one RAM word per column, read at the transaction,
  // written back when the cell leaves the window stage
  lgs_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_COLS)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (line_waddr),
    .wdata_i (line_wdata),
    .re_i    (accept),
    .raddr_i (col),
    .rdata_o (line_rdata)
  );

  // window stage and result register
  lgs_window #(
    .MAX_COLS (MAX_COLS)
  ) u_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .item_i       (item),
    .col_i        (col),
    .ready_o      (s1_ready),
    .line_rdata_i (line_rdata),
    .line_we_o    (line_we),
    .line_waddr_o (line_waddr),
    .line_wdata_o (line_wdata),
    .res_valid_o  (result_o.valid),
    .res_ready_i  (result_o.ready),
    .next_alive_o (result_o.next_alive),
    .out_row_o    (result_o.out_row),
    .out_col_o    (result_o.out_col),
    .last_cell_o  (result_o.last_cell)
  );

endmodule

// File: dv/tb_life_generation_step.sv
// Self-checking bench for life_generation_step: streams raster cell grids,
// predicts each B3/S23 interior result and checks the result stream in order.
// Depends on lgs_pkg and the lgs_*_if handshake interfaces.
module tb_life_generation_step;
  timeunit 1ns;
  timeprecision 1ps;

  import lgs_pkg::*;

  localparam int IDLE_PCT = 31;  // percent of cycles each side holds off
  localparam int SETTLE   = 8;   // cycles past the last result before a config write

  // One emitted interior cell, laid out like the result channel
  typedef struct packed {
    logic                 alive;
    logic [OUT_POS_W-1:0] row;
    logic [OUT_POS_W-1:0] col;
    logic                 last;
  } life_out_t;

  // Directed stimulus row; 'typed' rows carry a hand-written next state
  typedef struct packed {
    logic alive;
    logic start;
    logic typed;
    logic want_alive;
    logic want_last;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;
  bit   steady = 1'b0;   // set during the no-idle stretch
  int   errors = 0;

  lgs_cell_if   cell_if ();
  lgs_result_if res_if ();
  lgs_cfg_if    cfg_if ();

  life_generation_step uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cell_i  (cell_if),
    .result_o(res_if),
    .cfg_i   (cfg_if)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: our own copy of the line stores, window, scan position and
  // grid size registers. Line entries are only read after the frame's earlier
  // rows have been streamed, so their initial value never matters.
  // ---------------------------------------------------------------------------
  bit              row_up1 [MAX_COLS_DEF];   // cell values one row up
  bit              row_up2 [MAX_COLS_DEF];   // cell values two rows up
  logic [8:0]      nbhd      = '0;           // 3x3 window, oldest column in [2:0]
  int unsigned     at_row    = 0;            // position of the next cell
  int unsigned     at_col    = 0;
  logic [CFG_DATA_W-1:0] cfg_rows = CFG_DATA_W'(DIM_RESET);
  logic [CFG_DATA_W-1:0] cfg_cols = CFG_DATA_W'(DIM_RESET);

  life_out_t next_cells_q [$];   // interior next states still to come out

  // Directed frame: 5x5 grid, every input cell driven alive. The border is
  // forced dead, leaving a 3x3 live block: its corners survive with three
  // neighbors, edge centers and the middle have too many and die.
  dir_row_t dir_rows [25] = '{
    // row 0 (border)
    '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0}, '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0}, '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    // row 1
    '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0}, '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0}, '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    // row 2: emits interior row 1 from column 2 on
    '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0}, '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0}, '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0},
    '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0},
    // row 3: interior row 2, all crowded
    '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0}, '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0}, '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0},
    '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0},
    // row 4 (border): interior row 3, last cell flagged at the very end
    '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0}, '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0}, '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0},
    '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1}
  };

  // Register value to the size the block works with
  function automatic int unsigned eff_dim(logic [CFG_DATA_W-1:0] v, int unsigned top);
    if (v < MIN_DIM) return MIN_DIM;
    if (v > top) return top;
    return 32'(v);
  endfunction

  // Advance the grid model by one cell; returns 1 when an interior result is due
  function automatic bit life_rule_step(logic alive, logic start, output life_out_t res);
    int unsigned nr, nc, r, c, cnt;
    logic        cur;
    bit          got;
    nr  = eff_dim(cfg_rows, MAX_ROWS_DEF);
    nc  = eff_dim(cfg_cols, MAX_COLS_DEF);
    r   = at_row;
    c   = at_col;
    got = 1'b0;
    res = '0;
    // frame start or a position left outside a shrunk grid restarts at 0,0
    if (start || r >= nr || c >= nc) begin
      r = 0;
      c = 0;
    end
    cur = alive;
    if (r == 0 || c == 0 || r == nr - 1 || c == nc - 1) cur = 1'b0;  // border is dead
    // new column: [2] this row, [1] one up, [0] two up
    nbhd = {cur, row_up1[c], row_up2[c], nbhd[8:3]};
    row_up2[c] = row_up1[c];
    row_up1[c] = cur;
    if (r >= 2 && c >= 2) begin
      cnt       = $countones(nbhd & 9'h1EF);   // neighbors, center excluded
      res.alive = (cnt == 3) || (nbhd[4] && cnt == 2);
      res.row   = OUT_POS_W'(r - 1);
      res.col   = OUT_POS_W'(c - 1);
      res.last  = (r == nr - 1) && (c == nc - 1);
      got       = 1'b1;
    end
    // raster advance with wrap at the end of the grid
    if (c + 1 >= nc) begin
      c = 0;
      r = (r + 1 >= nr) ? 0 : r + 1;
    end else begin
      c = c + 1;
    end
    at_row = r;
    at_col = c;
    return got;
  endfunction

  task automatic flag(string msg);
    errors++;
    $display("[%0t] MISMATCH %s", $time, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Clock and run limit
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("** life_generation_step: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Config writes: both size registers back to back, valid held across the
  // pair so it only drops once.
  // ---------------------------------------------------------------------------
  task automatic set_grid(logic [CFG_DATA_W-1:0] rows_v, logic [CFG_DATA_W-1:0] cols_v);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= CFG_ROW_COUNT;
    cfg_if.data  <= rows_v;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_rows = rows_v;
    cfg_if.index <= CFG_COL_COUNT;
    cfg_if.data  <= cols_v;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_cols = cols_v;
    cfg_if.valid <= 1'b0;
  endtask

  // One cell transaction, with random hold-off in front of it. Valid stays up
  // between back-to-back cells; it is lowered only on an idle cycle.
  task automatic feed_cell(logic alive, logic start, logic typed = 1'b0,
                           logic want_alive = 1'b0, logic want_last = 1'b0);
    life_out_t res;
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      cell_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    cell_if.valid       <= 1'b1;
    cell_if.cell_alive  <= alive;
    cell_if.frame_start <= start;
    do @(posedge clk_i); while (!cell_if.ready);
    if (life_rule_step(alive, start, res)) begin
      if (typed) begin
        res.alive = want_alive;
        res.last  = want_last;
      end
      next_cells_q.push_back(res);
    end
  endtask

  // Drop valid, wait for every predicted result, then let the pipe empty.
  // Called in the time step of the last cell transaction.
  task automatic settle();
    cell_if.valid <= 1'b0;
    while (next_cells_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Random phase: new grid size, then mostly clean raster frames with random
  // cells. restart_pm is the per-mille chance of a frame start mid-frame.
  task automatic run_phase(logic [CFG_DATA_W-1:0] rows_v, logic [CFG_DATA_W-1:0] cols_v,
                           int n, int density, int restart_pm, bit calm);
    bit   in_grid;
    logic start;
    set_grid(rows_v, cols_v);
    steady  = calm;
    // a position still inside the new grid would read line entries written at
    // the old width, so the phase must open with a frame start; a position
    // outside the grid is left alone and the block restarts on its own
    in_grid = at_row < eff_dim(cfg_rows, MAX_ROWS_DEF) &&
              at_col < eff_dim(cfg_cols, MAX_COLS_DEF);
    for (int i = 0; i < n; i++) begin
      if (i == 0)
        start = in_grid;
      else if (at_row == 0 && at_col == 0)
        start = 1'($urandom_range(0, 1));    // marker at a frame boundary is optional
      else
        start = ($urandom_range(0, 999) < restart_pm);
      feed_cell($urandom_range(0, 99) < density, start);
    end
    settle();
    steady = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random backpressure, in-order field compare
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    life_out_t seen, want;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (res_if.valid && res_if.ready) begin
        seen = {res_if.next_alive, res_if.out_row, res_if.out_col, res_if.last_cell};
        if (next_cells_q.size() == 0) begin
          flag($sformatf("unexpected result row %0d col %0d", seen.row, seen.col));
        end else begin
          want = next_cells_q.pop_front();
          if (seen.row !== want.row)
            flag($sformatf("out_row: got %0d, expected %0d", seen.row, want.row));
          if (seen.col !== want.col)
            flag($sformatf("out_col: got %0d, expected %0d", seen.col, want.col));
          if (seen.alive !== want.alive)
            flag($sformatf("next_alive at (%0d,%0d): got %b, expected %b",
                           want.row, want.col, seen.alive, want.alive));
          if (seen.last !== want.last)
            flag($sformatf("last_cell at (%0d,%0d): got %b, expected %b",
                           want.row, want.col, seen.last, want.last));
        end
      end
      res_if.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    cell_if.valid       <= 1'b0;
    cell_if.cell_alive  <= 1'b0;
    cell_if.frame_start <= 1'b0;
    cfg_if.valid        <= 1'b0;
    cfg_if.index        <= CFG_ROW_COUNT;
    cfg_if.data         <= '0;
    rst_ni              <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: row count below the minimum is taken as 5, so this is 5x5
    set_grid(11'd3, 11'd5);
    foreach (dir_rows[k])
      feed_cell(dir_rows[k].alive, dir_rows[k].start, dir_rows[k].typed,
                dir_rows[k].want_alive, dir_rows[k].want_last);
    settle();

    // Smallest grid, many wraps and optional frame markers
    run_phase(11'd5,    11'd5,    150, 40, 5, 1'b0);
    // Tallest grid at its exact maximum, cols below minimum; ends at row 24
    run_phase(11'd1024, 11'd4,    120, 50, 0, 1'b0);
    // Shrink under the stored row position: block restarts without a marker
    run_phase(11'd8,    11'd11,   240, 35, 5, 1'b0);
    // Widest grid (register above maximum); too short to reach row 2, no results
    run_phase(11'd2047, 11'd2047, 60,  45, 0, 1'b0);
    // Full-width grid for ten cells, then narrow cols leave the column position outside
    run_phase(11'd13,   11'd1024, 10,  45, 0, 1'b0);
    run_phase(11'd6,    11'd9,    200, 30, 8, 1'b0);
    // Zero rows clamp to the minimum; dense population
    run_phase(11'd0,    11'd6,    200, 60, 5, 1'b0);
    // Reset-size grid, both sides streaming with no idle cycles
    run_phase(11'd64,   11'd64,   260, 38, 2, 1'b1);

    if (next_cells_q.size() != 0)
      flag($sformatf("%0d results never arrived", next_cells_q.size()));
    if (errors == 0) begin
      $display("** life_generation_step: PASSED **");
    end else begin
      $display("** life_generation_step: FAILED **");
    end
    $finish;
  end

endmodule
